@@ hdl/ric_pkg.sv @@
package ric_pkg;

  // pixel and coefficient format
  localparam int PIX_BITS  = 8;
  localparam int FRAC_BITS = 8;
  localparam int KROWS     = 5;
  localparam int KREG_BITS = 60;
  localparam int WIDTH_REG_BITS = 12;
  localparam int SEL_BITS  = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int ROW_BITS  = 16;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_SIZE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_ROW0 = 3'd2;

  typedef struct packed {
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic                frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] out_red;
    logic [PIX_BITS-1:0] out_green;
    logic [PIX_BITS-1:0] out_blue;
    logic                row_end;
  } pix_out_t;

endpackage

@@ hdl/rgb_image_convolution.sv @@
// channel  | direction | handshake              | beat
// pix      | in        | pix_valid / pix_stall  | one rgb pixel, raster order
// res      | out       | res_valid / res_stall  | one filtered pixel
// cfg      | in        | cfg_valid / cfg_ready  | register index and data
//
// one pixel per clock sustained while no result is stalled; a result passes the
// line store read, window shift, products and row sums registers, then the total
// and rounding feed the output register.
// the line store is one memory row per column, read and written back once per
// pixel; a repeat of the same column on the next beat is forwarded.
// rst is synchronous; the line store is not cleared.
// a stalled result holds the whole pipe and stalls the input.
module rgb_image_convolution #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_KERNEL = 5,
  parameter int COEF_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  ric_pkg::pix_in_t                    pix,
  output logic                                res_valid,
  input  logic                                res_stall,
  output ric_pkg::pix_out_t                   res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ric_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [ric_pkg::KREG_BITS-1:0]       cfg_data
);

  localparam int MK    = MAX_KERNEL;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = (CW + 1 > ric_pkg::WIDTH_REG_BITS) ? CW + 1 : ric_pkg::WIDTH_REG_BITS;
  localparam int PXW   = 3 * ric_pkg::PIX_BITS;
  localparam int LW    = PXW * (MK - 1);
  localparam int PW    = ric_pkg::PIX_BITS + COEF_BITS + 1;
  localparam int SW    = PW + 2 * $clog2(MK + 1);
  localparam int KW    = 4;
  localparam int PADW  = 64 + COEF_BITS;
  localparam int RB    = ric_pkg::ROW_BITS;

  // configuration registers
  logic [ric_pkg::SEL_BITS-1:0]       kernel_size_sel;
  logic [ric_pkg::WIDTH_REG_BITS-1:0] image_width;
  logic [ric_pkg::KREG_BITS-1:0]      kernel_rows [ric_pkg::KROWS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size_sel <= 2'd1;
      image_width     <= 12'd640;
      for (int i = 0; i < ric_pkg::KROWS; i++) begin
        kernel_rows[i] <= '0;
      end
      kernel_rows[2] <= ric_pkg::KREG_BITS'(64'd256 << (2 * COEF_BITS));
    end else if (cfg_valid) begin
      if (cfg_index == ric_pkg::CFG_KERNEL_SIZE) begin
        kernel_size_sel <= cfg_data[ric_pkg::SEL_BITS-1:0];
      end else if (cfg_index == ric_pkg::CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data[ric_pkg::WIDTH_REG_BITS-1:0];
      end else if (cfg_index >= ric_pkg::CFG_KERNEL_ROW0 &&
                   cfg_index < ric_pkg::CFG_KERNEL_ROW0 + 3'(ric_pkg::KROWS)) begin
        kernel_rows[cfg_index - ric_pkg::CFG_KERNEL_ROW0] <= cfg_data;
      end
    end
  end

  // kernel edge and effective width
  logic [KW-1:0] kdim;
  logic [KW-1:0] kbase;
  logic [WW-1:0] weff;
  always_comb begin
    logic [1:0] s;
    s = (kernel_size_sel > 2'd2) ? 2'd2 : kernel_size_sel;
    kdim = KW'(1) + KW'({s, 1'b0});
    if (kdim > KW'(MK)) kdim = KW'(MK);
    kbase = KW'((KW'(ric_pkg::KROWS) - kdim) >> 1);
    if (image_width == '0 || WW'(image_width) > WW'(MAX_WIDTH)) weff = WW'(MAX_WIDTH);
    else weff = WW'(image_width);
  end

  // coefficient per window tap, registered from the configuration
  logic signed [COEF_BITS-1:0] coef [MK][MK];
  always_ff @(posedge clk) begin
    for (int r = 0; r < MK; r++) begin
      for (int c = 0; c < MK; c++) begin
        int kr;
        int kc;
        logic [PADW-1:0] padded;
        kr = int'(kbase) + int'(kdim) - 1 - r;
        kc = int'(kbase) + int'(kdim) - 1 - c;
        if (r < int'(kdim) && c < int'(kdim) && kr < ric_pkg::KROWS &&
            kc * COEF_BITS < 64) begin
          padded = PADW'(kernel_rows[kr]);
          coef[r][c] <= COEF_BITS'(padded >> (kc * COEF_BITS));
        end else begin
          coef[r][c] <= '0;
        end
      end
    end
  end

  // pipeline advance
  logic adv;
  logic pix_accept;
  assign adv        = !(res_valid && res_stall);
  assign pix_stall  = !adv;
  assign pix_accept = pix_valid && adv;

  // column and row position of the arriving pixel
  logic [CW-1:0] column_count, column_count_next;
  logic [RB-1:0] row_count, row_count_next;
  logic [CW-1:0] col;
  logic          produce;
  logic          last;
  always_comb begin
    logic [WW-1:0] cc;
    logic [RB-1:0] rc;
    cc = pix.frame_start ? '0 : WW'(column_count);
    rc = pix.frame_start ? '0 : row_count;
    if (cc >= weff) begin
      cc = '0;
      if (rc != {RB{1'b1}}) rc = rc + RB'(1);
    end
    col     = cc[CW-1:0];
    produce = (rc >= RB'(kdim - KW'(1))) && (cc >= WW'(kdim - KW'(1)));
    last    = (cc + WW'(1) >= weff);
    if (last) begin
      column_count_next = '0;
      row_count_next    = (rc != {RB{1'b1}}) ? rc + RB'(1) : rc;
    end else begin
      column_count_next = CW'(cc + WW'(1));
      row_count_next    = rc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pix_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // stage 1: line store read in flight
  logic          s1_valid;
  logic [PXW-1:0] s1_pix;
  logic [CW-1:0] s1_col;
  logic          s1_produce;
  logic          s1_last;
  logic          s1_fwd;
  logic [LW-1:0] line_rd;
  logic [LW-1:0] line_wr;
  logic [LW-1:0] line_wr_last;
  logic [LW-1:0] line_cur;
  logic [LW-1:0] line_mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_pix     <= {pix.blue, pix.green, pix.red};
      s1_col     <= col;
      s1_produce <= produce;
      s1_last    <= last;
      s1_fwd     <= s1_valid && (s1_col == col);
    end
  end

  // line store read port
  always_ff @(posedge clk) begin
    if (pix_accept) begin
      line_rd <= line_mem[col];
    end
  end

  assign line_cur = s1_fwd ? line_wr_last : line_rd;

  generate
    if (MK > 2) begin : g_cascade
      assign line_wr = {line_cur[LW-PXW-1:0], s1_pix};
    end else begin : g_single
      assign line_wr = s1_pix;
    end
  endgenerate

  // line store write port, cascade rows for this column
  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      line_mem[s1_col] <= line_wr;
      line_wr_last     <= line_wr;
    end
  end

  // stage 2: sliding window, newest column at index 0
  logic [PXW-1:0] window_regs [MK][MK];
  logic           s2_valid;
  logic           s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int r = 0; r < MK; r++) begin
        for (int c = 0; c < MK; c++) begin
          window_regs[r][c] <= '0;
        end
      end
    end else if (adv) begin
      s2_valid <= s1_valid && s1_produce;
      if (s1_valid) begin
        for (int r = 0; r < MK; r++) begin
          for (int c = MK - 1; c > 0; c--) begin
            window_regs[r][c] <= window_regs[r][c-1];
          end
        end
        window_regs[0][0] <= s1_pix;
        for (int r = 1; r < MK; r++) begin
          window_regs[r][0] <= line_cur[(r-1)*PXW +: PXW];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_last <= s1_last;
    end
  end

  // stage 3: products per tap and channel, taps outside the kernel give zero
  logic              s3_valid;
  logic              s3_last;
  logic signed [PW-1:0] prod [MK][MK][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      for (int r = 0; r < MK; r++) begin
        for (int c = 0; c < MK; c++) begin
          for (int ch = 0; ch < 3; ch++) begin
            if (r < int'(kdim) && c < int'(kdim)) begin
              prod[r][c][ch] <= PW'($signed({1'b0,
                window_regs[r][c][ch*ric_pkg::PIX_BITS +: ric_pkg::PIX_BITS]})) *
                PW'(coef[r][c]);
            end else begin
              prod[r][c][ch] <= '0;
            end
          end
        end
      end
    end
  end

  // stage 4: row sums
  logic              s4_valid;
  logic              s4_last;
  logic signed [SW-1:0] row_sum [MK][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_last <= s3_last;
      for (int r = 0; r < MK; r++) begin
        for (int ch = 0; ch < 3; ch++) begin
          logic signed [SW-1:0] acc;
          acc = '0;
          for (int c = 0; c < MK; c++) begin
            acc = acc + SW'(prod[r][c][ch]);
          end
          row_sum[r][ch] <= acc;
        end
      end
    end
  end

  // total, round half away from zero, saturate
  logic [ric_pkg::PIX_BITS-1:0] chan [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [SW-1:0] tot;
      logic signed [SW-1:0] q;
      tot = '0;
      for (int r = 0; r < MK; r++) begin
        tot = tot + row_sum[r][ch];
      end
      q = (tot + SW'(1 << (ric_pkg::FRAC_BITS - 1))) >>> ric_pkg::FRAC_BITS;
      if (tot <= 0) chan[ch] = '0;
      else if (q > SW'(255)) chan[ch] = 8'd255;
      else chan[ch] = q[ric_pkg::PIX_BITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.out_red   <= chan[0];
      res.out_green <= chan[1];
      res.out_blue  <= chan[2];
      res.row_end   <= s4_last;
    end
  end

endmodule

@@ verif/ric_checker.sv @@
`timescale 1ns / 100ps

module ric_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  input  logic                             pix_stall,
  input  ric_pkg::pix_in_t                 pix,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  ric_pkg::pix_out_t                res,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ric_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ric_pkg::KREG_BITS-1:0]    cfg_data,
  output int                               errors,
  output int                               pending
);

  localparam int NLINES = 4;
  localparam int MAXW   = 2048;
  localparam int MAXK   = 5;
  localparam int CBITS  = 12;

  logic [23:0]          line_mem [NLINES][MAXW];
  logic [23:0]          win [MAXK][MAXK];
  int unsigned          col_cnt;
  int unsigned          row_cnt;
  logic [ric_pkg::SEL_BITS-1:0]       ksel;
  logic [ric_pkg::WIDTH_REG_BITS-1:0] img_w;
  logic [ric_pkg::KREG_BITS-1:0]      krow [ric_pkg::KROWS];
  ric_pkg::pix_out_t    filtered_q [$];

  // signed q4.8 coefficient of kernel row r, column c
  function automatic int coef(int r, int c);
    logic [CBITS-1:0] v;
    v = krow[r][c*CBITS +: CBITS];
    return int'($signed(v));
  endfunction

  // round half away from zero, clamp to a byte
  function automatic logic [7:0] round_clamp(int s);
    int q;
    if (s <= 0) return 8'd0;
    q = (s + (1 << (ric_pkg::FRAC_BITS - 1))) >>> ric_pkg::FRAC_BITS;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // advance the window for one accepted pixel and queue any filtered pixel
  task automatic take_pixel(ric_pkg::pix_in_t p);
    int unsigned k, base, w, col;
    int sum [3];
    logic [23:0] px, q;
    bit make;
    ric_pkg::pix_out_t o;
    k    = (ksel >= 2) ? 5 : 1 + 2 * ksel;
    base = (ric_pkg::KROWS - k) / 2;
    w    = (img_w == 0 || img_w > MAXW) ? MAXW : img_w;
    if (p.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      if (row_cnt < 65535) row_cnt++;
    end
    col = col_cnt;
    px  = {p.blue, p.green, p.red};
    for (int i = 0; i < MAXK; i++)
      for (int j = MAXK - 1; j > 0; j--)
        win[i][j] = win[i][j-1];
    win[0][0] = px;
    for (int i = 1; i < MAXK; i++) win[i][0] = line_mem[i-1][col];
    for (int i = NLINES - 1; i > 0; i--) line_mem[i][col] = line_mem[i-1][col];
    line_mem[0][col] = px;
    make = (row_cnt >= k - 1) && (col >= k - 1);
    if (col + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < 65535) row_cnt++;
    end else begin
      col_cnt = col + 1;
    end
    if (make) begin
      sum = '{0, 0, 0};
      for (int i = 0; i < k; i++)
        for (int j = 0; j < k; j++) begin
          q = win[k-1-i][k-1-j];
          for (int ch = 0; ch < 3; ch++)
            sum[ch] += int'(q[8*ch +: 8]) * coef(base + i, base + j);
        end
      o.out_red   = round_clamp(sum[0]);
      o.out_green = round_clamp(sum[1]);
      o.out_blue  = round_clamp(sum[2]);
      o.row_end   = (col + 1 >= w);
      filtered_q.push_back(o);
    end
  endtask

  // compare one result beat with the oldest filtered pixel
  task automatic check_result(ric_pkg::pix_out_t got);
    ric_pkg::pix_out_t exp_px;
    if (filtered_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result %h", $realtime, got);
    end else begin
      exp_px = filtered_q.pop_front();
      if (got.out_red !== exp_px.out_red) begin
        errors++;
        $display("%0t: out_red exp %0d got %0d", $realtime, exp_px.out_red, got.out_red);
      end
      if (got.out_green !== exp_px.out_green) begin
        errors++;
        $display("%0t: out_green exp %0d got %0d", $realtime, exp_px.out_green,
                 got.out_green);
      end
      if (got.out_blue !== exp_px.out_blue) begin
        errors++;
        $display("%0t: out_blue exp %0d got %0d", $realtime, exp_px.out_blue, got.out_blue);
      end
      if (got.row_end !== exp_px.row_end) begin
        errors++;
        $display("%0t: row_end exp %0d got %0d", $realtime, exp_px.row_end, got.row_end);
      end
    end
  endtask

  // watch the three channels
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NLINES; i++)
        for (int j = 0; j < MAXW; j++) line_mem[i][j] = '0;
      for (int i = 0; i < MAXK; i++)
        for (int j = 0; j < MAXK; j++) win[i][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
      ksel    = 2'd1;
      img_w   = 12'd640;
      for (int i = 0; i < ric_pkg::KROWS; i++) krow[i] = '0;
      krow[2][2*12 +: 12] = 12'd256;
      filtered_q.delete();
    end else begin
      if (res_valid && !res_stall) check_result(res);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ric_pkg::CFG_KERNEL_SIZE)
          ksel = cfg_data[ric_pkg::SEL_BITS-1:0];
        else if (cfg_index == ric_pkg::CFG_IMAGE_WIDTH)
          img_w = cfg_data[ric_pkg::WIDTH_REG_BITS-1:0];
        else if (cfg_index >= ric_pkg::CFG_KERNEL_ROW0 &&
                 cfg_index < ric_pkg::CFG_KERNEL_ROW0 + ric_pkg::KROWS)
          krow[cfg_index - ric_pkg::CFG_KERNEL_ROW0] = cfg_data;
      end
      if (pix_valid && !pix_stall) take_pixel(pix);
    end
    pending = filtered_q.size();
  end

endmodule

@@ verif/rgb_image_convolution_tb.sv @@
`timescale 1ns / 100ps

module rgb_image_convolution_tb;

  logic                             clk;
  logic                             rst;
  logic                             pix_valid;
  logic                             pix_stall;
  ric_pkg::pix_in_t                 pix;
  logic                             res_valid;
  logic                             res_stall;
  ric_pkg::pix_out_t                res;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [ric_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [ric_pkg::KREG_BITS-1:0]    cfg_data;
  int                               errors;
  int                               pending;

  // receiver behaviour
  int stall_mode;
  int hold_reqs;
  int hold_seen;
  int hold_off;
  int stall_tick;
  // sender burst state
  int burst_left;
  int pixels_sent;
  int prev_w;

  rgb_image_convolution u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ric_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_off  <= 300;
      res_stall <= 1'b1;
    end else if (hold_off > 0) begin
      res_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else begin
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 3) != 0);
        default: res_stall <= ((stall_tick % 14) < 6);
      endcase
    end
  end

  // one register write beat
  task automatic write_reg(logic [ric_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [ric_pkg::KREG_BITS-1:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one pixel beat, then maybe a gap
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    bit ok;
    pix_valid <= 1'b1;
    pix       <= '{red: r, green: g, blue: b, frame_start: fs};
    do begin
      @(negedge clk);
      ok = !pix_stall;
      @(posedge clk);
    end while (!ok);
    pixels_sent++;
    if (--burst_left <= 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  // wait until every filtered pixel is in, then let the pipe empty
  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  // five 12-bit coefficients for one kernel row
  function automatic logic [ric_pkg::KREG_BITS-1:0] kernel_row(int mode);
    logic [ric_pkg::KREG_BITS-1:0] v;
    for (int c = 0; c < 5; c++) begin
      case (mode)
        0: v[c*12 +: 12] = 12'h7ff;
        1: v[c*12 +: 12] = 12'h800;
        2: v[c*12 +: 12] = 12'($signed($urandom_range(0, 128)) - 64);
        default: v[c*12 +: 12] = 12'($urandom);
      endcase
    end
    return v;
  endfunction

  task automatic set_kernel(logic [1:0] sel, logic [11:0] w, int mode);
    write_reg(ric_pkg::CFG_KERNEL_SIZE, ric_pkg::KREG_BITS'(sel));
    write_reg(ric_pkg::CFG_IMAGE_WIDTH, ric_pkg::KREG_BITS'(w));
    for (int r = 0; r < ric_pkg::KROWS; r++)
      write_reg(ric_pkg::CFG_KERNEL_ROW0 + r[ric_pkg::CFG_IDX_BITS-1:0],
                ($urandom_range(0, 9) == 0) ? kernel_row(3) : kernel_row(mode));
  endtask

  function automatic int eff_width(logic [11:0] w);
    return (w == 0 || w > 2048) ? 2048 : int'(w);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // a frame of random pixels, a stray frame start now and then
  task automatic send_frame(int w, int rows, bit fs_first);
    for (int i = 0; i < w * rows; i++)
      send_pixel(rand_byte(), rand_byte(), rand_byte(),
                 (i == 0) ? fs_first : ($urandom_range(0, 199) == 0));
  endtask

  initial begin
    logic [1:0]  sel;
    logic [11:0] w;
    int          k;
    rst        = 1'b1;
    pix_valid  = 1'b0;
    pix        = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    stall_mode = 0;
    hold_reqs  = 0;
    burst_left = 1000;
    pixels_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset kernel, identity 3x3 over width 3
    write_reg(ric_pkg::CFG_IMAGE_WIDTH, ric_pkg::KREG_BITS'(3));
    send_pixel(8'd0, 8'd255, 8'd1, 1'b1);
    for (int i = 1; i < 9; i++) send_pixel(8'(i * 31), 8'd255, 8'd0, 1'b0);
    drain();

    // 1x1 half coefficient: rounding ties go up
    write_reg(ric_pkg::CFG_KERNEL_SIZE, ric_pkg::KREG_BITS'(0));
    write_reg(ric_pkg::CFG_IMAGE_WIDTH, ric_pkg::KREG_BITS'(2));
    write_reg(ric_pkg::CFG_KERNEL_ROW0 + 3'd2, ric_pkg::KREG_BITS'(12'd128) << 24);
    send_pixel(8'd1, 8'd3, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd2, 8'd254, 1'b0);
    drain();

    // negative centre saturates to zero; maximum kernel of size selector three
    write_reg(ric_pkg::CFG_KERNEL_ROW0 + 3'd2, ric_pkg::KREG_BITS'(12'h800) << 24);
    send_pixel(8'd200, 8'd1, 8'd0, 1'b1);
    drain();
    set_kernel(2'd3, 12'd5, 0);
    send_frame(5, 6, 1'b1);
    drain();

    // widest rows: width zero and width beyond the maximum, no row end yet
    stall_mode = 1;
    set_kernel(2'd0, 12'd0, 2);
    send_frame(300, 1, 1'b1);
    drain();
    set_kernel(2'd0, 12'd4095, 2);
    send_frame(300, 1, 1'b1);
    drain();

    // long receiver hold-off while pixels keep coming
    stall_mode = 0;
    set_kernel(2'd0, 12'd24, 2);
    hold_reqs++;
    send_frame(24, 6, 1'b1);
    drain();
    prev_w = 0;

    // random phases
    while (pixels_sent < 2000) begin
      stall_mode = $urandom_range(0, 3);
      sel = 2'($urandom_range(0, 3));
      w   = ($urandom_range(0, 9) == 0) ? 12'd1 : 12'($urandom_range(2, 24));
      set_kernel(sel, w, $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2);
      k = (sel >= 2) ? 5 : 1 + 2 * sel;
      if ($urandom_range(0, 9) == 0) hold_reqs++;
      // a narrower row may carry on the frame already started
      send_frame(eff_width(w), k + $urandom_range(0, 4),
                 !(eff_width(w) <= prev_w && $urandom_range(0, 2) == 0));
      prev_w = eff_width(w);
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ric_pkg.sv
hdl/rgb_image_convolution.sv
verif/ric_checker.sv
verif/rgb_image_convolution_tb.sv
